[rtl/tpd_pkg.sv]
// Package: shared types and constants of the typed packet deframer.
`default_nettype none

package tpd_pkg;

  localparam int unsigned CntW       = 13;
  localparam int unsigned MaxPayload = 4096;
  localparam int unsigned HdrBytes   = 4;
  localparam logic [CntW-1:0] FieldLast = CntW'(HdrBytes - 1);
  localparam logic [31:0] ByeTag = 32'h6279_655F;  // "bye_"

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_TAG      = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_BYE      = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_EXPECTED_TAG    = 1'b0,
    CFG_EXPECTED_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

endpackage

`default_nettype wire

[rtl/tpd_if.sv]
// Interfaces: received byte channel, result channel and register write channel.
`default_nettype none

interface tpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tpd_out_if;
  logic                 valid;
  logic                 ready;
  tpd_pkg::kind_e       kind;
  logic [7:0]           payload_byte;
  tpd_pkg::status_e     status;
  logic                 link_closed;

  modport source (output valid, output kind, output payload_byte, output status,
                  output link_closed, input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input link_closed, output ready);
endinterface

interface tpd_cfg_if;
  logic              valid;
  logic              ready;
  tpd_pkg::cfg_idx_e idx;
  logic [31:0]       wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/typed_packet_deframer_sum_check.sv]
// Top level: packet deframer with additive checksum check.
//
// Usage:
//   in_i   carries one received link byte per item. Packets are a 4-byte
//          tag, a 4-byte length (MSB first), the payload and a 4-byte
//          checksum (LSB first) holding the 32-bit sum of the payload bytes.
//   out_o  gives at most one item per received byte: each payload byte as it
//          arrives (kind 0), and one status after a bad header or after the
//          checksum (kind 1). link_closed stays set once a rejected tag was a bye tag.
//   cfg_i  writes expected_tag (index 0) or expected_length (index 1); it is
//          always ready and is meant to be used while no packet is under way.
// Timing: one byte per cycle unless out_o stalls; a result appears on out_o the
//   cycle after its byte is taken, held in a single output register.
// Stalls: in_i stays ready while the output register is empty or being
//   drained, so a stalled receiver holds off input after one pending result.
// Reset: rst_ni clears the parser to wait for a tag, clears both registers
//   and the closed flag, and empties the output register.
`default_nettype none

module typed_packet_deframer_sum_check (
  input  wire               clk_i,
  input  wire               rst_ni,
  tpd_in_if.sink            in_i,
  tpd_out_if.source         out_o,
  tpd_cfg_if.sink           cfg_i
);

  tpd_pkg::phase_e            phase_q, phase_d;
  logic [tpd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]                tag_q, tag_d;
  logic [31:0]                len_q, len_d;
  logic [31:0]                sum_q, sum_d;
  logic [31:0]                chk_q, chk_d;
  logic                       closed_q, closed_d;
  logic [31:0]                exp_tag_q;
  logic [tpd_pkg::CntW-1:0]   exp_len_q;

  logic                       out_valid_q, out_valid_d;
  tpd_pkg::kind_e             kind_q;
  logic [7:0]                 pbyte_q;
  tpd_pkg::status_e           status_q;
  logic                       closed_out_q;

  logic                       in_acc;
  logic                       res_valid;
  tpd_pkg::kind_e             res_kind;
  logic [7:0]                 res_byte;
  tpd_pkg::status_e           res_status;
  logic [tpd_pkg::CntW:0]     data_cnt;
  logic [7:0]                 b;

  // String compare: a byte pair of zeros ends the tag early as a match.
  function automatic logic tag_match(input logic [31:0] want, input logic [31:0] got);
    logic done;
    logic ok;
    done = 1'b0;
    ok   = 1'b1;
    for (int i = 3; i >= 0; i--) begin
      if (!done) begin
        if (want[i*8 +: 8] != got[i*8 +: 8]) begin
          ok   = 1'b0;
          done = 1'b1;
        end else if (want[i*8 +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return ok;
  endfunction

  assign b        = in_i.rx_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign data_cnt = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    tag_d      = tag_q;
    len_d      = len_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    closed_d   = closed_q;
    res_valid  = 1'b0;
    res_kind   = tpd_pkg::KIND_STATUS;
    res_byte   = 8'd0;
    res_status = tpd_pkg::ST_OK;

    unique case (phase_q)
      tpd_pkg::PH_TAG: begin
        tag_d = {tag_q[23:0], b};
        if (cnt_q == tpd_pkg::FieldLast) begin
          phase_d = tpd_pkg::PH_LEN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tpd_pkg::PH_LEN: begin
        len_d = {len_q[23:0], b};
        if (cnt_q != tpd_pkg::FieldLast) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!tag_match(exp_tag_q, tag_q)) begin
          res_valid = 1'b1;
          if (tag_q == tpd_pkg::ByeTag) begin
            closed_d   = 1'b1;
            res_status = tpd_pkg::ST_BYE;
          end else begin
            res_status = tpd_pkg::ST_TAG;
          end
        end else if (len_d != {{(32-tpd_pkg::CntW){1'b0}}, exp_len_q} ||
                     exp_len_q > tpd_pkg::CntW'(tpd_pkg::MaxPayload)) begin
          res_valid  = 1'b1;
          res_status = tpd_pkg::ST_LENGTH;
        end else begin
          cnt_d   = '0;
          sum_d   = '0;
          phase_d = (exp_len_q == '0) ? tpd_pkg::PH_CHECK : tpd_pkg::PH_DATA;
        end
      end
      tpd_pkg::PH_DATA: begin
        sum_d     = sum_q + {24'd0, b};
        res_valid = 1'b1;
        res_kind  = tpd_pkg::KIND_PAYLOAD;
        res_byte  = b;
        if (data_cnt >= {1'b0, exp_len_q}) begin
          phase_d = tpd_pkg::PH_CHECK;
          cnt_d   = '0;
        end else begin
          cnt_d = data_cnt[tpd_pkg::CntW-1:0];
        end
      end
      tpd_pkg::PH_CHECK: begin
        chk_d = {b, chk_q[31:8]};
        if (cnt_q != tpd_pkg::FieldLast) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          res_valid  = 1'b1;
          res_status = (chk_d == sum_q) ? tpd_pkg::ST_OK : tpd_pkg::ST_CHECKSUM;
        end
      end
      default: begin
        phase_d = tpd_pkg::PH_TAG;
      end
    endcase

    // Any status ends the packet: back to waiting for a tag.
    if (res_valid && res_kind == tpd_pkg::KIND_STATUS) begin
      phase_d = tpd_pkg::PH_TAG;
      cnt_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      sum_d   = '0;
      chk_d   = '0;
    end
  end

  assign out_valid_d = in_acc ? res_valid : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tpd_pkg::PH_TAG;
      cnt_q       <= '0;
      tag_q       <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      closed_q    <= 1'b0;
      exp_tag_q   <= '0;
      exp_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        tag_q    <= tag_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
        chk_q    <= chk_d;
        closed_q <= closed_d;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.idx)
          tpd_pkg::CFG_EXPECTED_TAG:    exp_tag_q <= cfg_i.wdata;
          tpd_pkg::CFG_EXPECTED_LENGTH: exp_len_q <= cfg_i.wdata[tpd_pkg::CntW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q       <= res_kind;
      pbyte_q      <= res_byte;
      status_q     <= res_status;
      closed_out_q <= closed_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.payload_byte = pbyte_q;
  assign out_o.status       = status_q;
  assign out_o.link_closed  = closed_out_q;

endmodule

`default_nettype wire

[rtl/tpd_checker.sv]
// Checker on the deframer's result port, bound to the top level.
`default_nettype none

module tpd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       kind_i,
  input wire [7:0] payload_byte_i,
  input wire [2:0] status_i,
  input wire       link_closed_i
);

  // Status codes above bye never occur.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= tpd_pkg::ST_BYE)
    else $error("status code out of range");

  // Payload items carry no status.
  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tpd_pkg::KIND_PAYLOAD |-> status_i == tpd_pkg::ST_OK)
    else $error("payload item with nonzero status");

  // Status items carry a zero byte.
  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tpd_pkg::KIND_STATUS |-> payload_byte_i == 8'd0)
    else $error("status item with nonzero payload byte");

  // A bye status already reports the link as closed.
  a_bye_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == tpd_pkg::ST_BYE |-> link_closed_i)
    else $error("bye status without link_closed");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(payload_byte_i) && $stable(status_i) && $stable(link_closed_i))
    else $error("stalled result item changed");

endmodule

bind typed_packet_deframer_sum_check tpd_checker u_tpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .payload_byte_i (out_o.payload_byte),
  .status_i       (out_o.status),
  .link_closed_i  (out_o.link_closed)
);

`default_nettype wire

[verif/typed_packet_deframer_sum_check_test.sv]
// Testbench: random and directed byte streams into the packet deframer, checked against a predictor.
`default_nettype none

module typed_packet_deframer_sum_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
    logic       closed;
  } frame_res_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    frame_res_t res;
  } dir_row_t;

  localparam frame_res_t NoRes = '{KIND_PAYLOAD, 8'h00, ST_OK, 1'b0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tpd_in_if  in_if ();
  tpd_out_if out_if ();
  tpd_cfg_if cfg_if ();

  typed_packet_deframer_sum_check uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] cfg_tag;
  logic [12:0] cfg_len;
  phase_e      parse_phase;
  logic [12:0] byte_cnt;
  logic [31:0] tag_shift;
  logic [31:0] len_shift;
  logic [31:0] data_sum;
  logic [31:0] chk_shift;
  logic        bye_seen;

  frame_res_t  due_outputs[$];
  frame_res_t  oldest_due;
  int unsigned items_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int          send_idle   = 0;
  int          recv_idle   = 0;

  // Good packet with one payload byte, then a bye packet that closes the link
  dir_row_t dir_rows [0:20] = '{
    '{8'h64, 1'b0, NoRes}, '{8'h61, 1'b0, NoRes}, '{8'h74, 1'b0, NoRes},
    '{8'h5F, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h01, 1'b0, NoRes},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, ST_OK, 1'b0}},
    '{8'hFF, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b1, '{KIND_STATUS, 8'h00, ST_OK, 1'b0}},
    '{8'h62, 1'b0, NoRes}, '{8'h79, 1'b0, NoRes}, '{8'h65, 1'b0, NoRes},
    '{8'h5F, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b1, '{KIND_STATUS, 8'h00, ST_BYE, 1'b1}}
  };

  logic [31:0] phase_tag [0:5] = '{
    32'h6461_745F, 32'h0000_0000, 32'h4142_0000, 32'hFFFF_FFFF, ByeTag, 32'h7A00_7A7A
  };
  // all-ones length write lands on 8191, above the payload capacity
  logic [31:0] phase_len [0:5] = '{
    32'd5, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd7
  };

  // string compare of up to four chars, stops at a shared NUL
  function automatic bit tag_accepts(logic [31:0] want, logic [31:0] got);
    int i;
    for (i = 3; i >= 0; i--) begin
      if (want[8*i +: 8] != got[8*i +: 8]) return 1'b0;
      if (want[8*i +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic rewind_parser();
    parse_phase = PH_TAG;
    byte_cnt    = '0;
    tag_shift   = '0;
    len_shift   = '0;
    data_sum    = '0;
    chk_shift   = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_res_t res);
    got = 1'b0;
    res = NoRes;
    case (parse_phase)
      PH_LEN: begin
        len_shift = {len_shift[23:0], b};
        byte_cnt++;
        if (byte_cnt == 13'd4) begin
          got      = 1'b1;
          res.kind = KIND_STATUS;
          if (!tag_accepts(cfg_tag, tag_shift)) begin
            res.status = ST_TAG;
            if (tag_shift == ByeTag) begin
              bye_seen   = 1'b1;
              res.status = ST_BYE;
            end
            rewind_parser();
          end else if (len_shift != {19'd0, cfg_len} || cfg_len > MaxPayload) begin
            res.status = ST_LENGTH;
            rewind_parser();
          end else begin
            got         = 1'b0;
            byte_cnt    = '0;
            data_sum    = '0;
            parse_phase = (cfg_len == 13'd0) ? PH_CHECK : PH_DATA;
          end
          res.closed = bye_seen;
        end
      end
      PH_DATA: begin
        data_sum = data_sum + {24'd0, b};
        byte_cnt++;
        if (byte_cnt >= cfg_len) begin
          parse_phase = PH_CHECK;
          byte_cnt    = '0;
        end
        got        = 1'b1;
        res.kind   = KIND_PAYLOAD;
        res.data   = b;
        res.closed = bye_seen;
      end
      PH_CHECK: begin
        // checksum arrives LSB first
        chk_shift = {b, chk_shift[31:8]};
        byte_cnt++;
        if (byte_cnt == 13'd4) begin
          got        = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = (chk_shift == data_sum) ? ST_OK : ST_CHECKSUM;
          res.closed = bye_seen;
          rewind_parser();
        end
      end
      default: begin
        tag_shift = {tag_shift[23:0], b};
        byte_cnt++;
        if (byte_cnt >= 13'd4) begin
          parse_phase = PH_LEN;
          byte_cnt    = '0;
        end
      end
    endcase
  endtask

  // called just after a falling edge; returns just after a falling edge
  task automatic push_byte(input logic [7:0] b, input bit typed, input frame_res_t typed_res);
    bit         got;
    frame_res_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.rx_byte = b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    deframe_byte(b, got, res);
    if (typed) due_outputs.push_back(typed_res);
    else if (got) due_outputs.push_back(res);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_if.idx   = idx;
    cfg_if.wdata = data;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_EXPECTED_TAG:    cfg_tag = data;
      CFG_EXPECTED_LENGTH: cfg_len = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // feed filler until the parser is back waiting for a tag
  task automatic flush_parser();
    while (parse_phase != PH_TAG || byte_cnt != '0) push_byte(8'($urandom), 1'b0, NoRes);
  endtask

  task automatic send_packet();
    int unsigned flavor;
    int unsigned n;
    int          i;
    logic [31:0] tag;
    logic [31:0] len;
    logic [31:0] sum;
    logic [7:0]  b;
    bit          stopped;
    flavor  = $urandom_range(0, 99);
    len     = {19'd0, cfg_len};
    tag     = cfg_tag;
    stopped = 1'b0;
    // bytes after a NUL in the expected tag are don't-care
    for (i = 3; i >= 0; i--) begin
      if (stopped) tag[8*i +: 8] = 8'($urandom);
      else if (cfg_tag[8*i +: 8] == 8'h00) stopped = 1'b1;
    end
    if (flavor >= 95) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom), 1'b0, NoRes);
      flush_parser();
      return;
    end
    if (flavor >= 88) tag = ByeTag;
    else if (flavor >= 80) tag = flavor[0] ? $urandom : tag ^ (32'h1 << $urandom_range(0, 31));
    else if (flavor >= 70) len = len ^ (32'h1 << $urandom_range(0, 31));
    for (i = 3; i >= 0; i--) push_byte(tag[8*i +: 8], 1'b0, NoRes);
    for (i = 3; i >= 0; i--) push_byte(len[8*i +: 8], 1'b0, NoRes);
    if (parse_phase == PH_TAG) return;
    sum = '0;
    repeat (cfg_len) begin
      b   = 8'($urandom);
      sum = sum + {24'd0, b};
      push_byte(b, 1'b0, NoRes);
    end
    if ($urandom_range(0, 4) == 0) sum = sum ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++) push_byte(sum[8*i +: 8], 1'b0, NoRes);
  endtask

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%s", msg);
  endtask

  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_outputs.size() == 0) begin
        flag_failure($sformatf("unexpected item: kind=%0d byte=%02h status=%0d closed=%0d",
                               out_if.kind, out_if.payload_byte, out_if.status,
                               out_if.link_closed));
      end else begin
        oldest_due = due_outputs.pop_front();
        if (out_if.kind !== oldest_due.kind || out_if.payload_byte !== oldest_due.data ||
            out_if.status !== oldest_due.status || out_if.link_closed !== oldest_due.closed) begin
          flag_failure($sformatf(
            "mismatch: want kind=%0d byte=%02h status=%0d closed=%0d, got %0d %02h %0d %0d",
            oldest_due.kind, oldest_due.data, oldest_due.status, oldest_due.closed,
            out_if.kind, out_if.payload_byte, out_if.status, out_if.link_closed));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("typed_packet_deframer_sum_check verification failed");
      $finish;
    end
  end

  initial begin
    int p;
    int unsigned phase_end;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.idx    = CFG_EXPECTED_TAG;
    cfg_if.wdata  = 32'h0;
    cfg_tag  = '0;
    cfg_len  = '0;
    bye_seen = 1'b0;
    rewind_parser();
    send_idle = 16;
    recv_idle = 78;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_EXPECTED_TAG, 32'h6461_745F);
    write_reg(CFG_EXPECTED_LENGTH, 32'd1);
    foreach (dir_rows[r]) push_byte(dir_rows[r].rx, dir_rows[r].typed, dir_rows[r].res);
    settle();

    // two settings per idle pattern: receiver sparse, sender sparse, none
    for (p = 0; p < 6; p++) begin
      send_idle = (p / 2 == 0) ? 16 : (p / 2 == 1) ? 78 : 0;
      recv_idle = (p / 2 == 0) ? 78 : (p / 2 == 1) ? 16 : 0;
      write_reg(CFG_EXPECTED_TAG, phase_tag[p]);
      write_reg(CFG_EXPECTED_LENGTH, phase_len[p]);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_packet();
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("typed_packet_deframer_sum_check verification clean");
    end else begin
      $display("typed_packet_deframer_sum_check verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/tpd_pkg.sv
rtl/tpd_if.sv
rtl/typed_packet_deframer_sum_check.sv
rtl/tpd_checker.sv
verif/typed_packet_deframer_sum_check_test.sv
